// ===== hdl/sxd_pkg.sv =====
package sxd_pkg;

  // Frame parser phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN_HIGH,
    PH_LEN_LOW,
    PH_BODY,
    PH_READ,
    PH_LOAD
  } phase_e;

  // Result status codes
  localparam logic [1:0] ST_BODY     = 2'd0;
  localparam logic [1:0] ST_BAD_SUM  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // Sync byte after reset
  localparam logic [7:0] SYNC_RESET = 8'h13;

endpackage

// ===== hdl/sxd_buf.sv =====
module sxd_buf #(
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sync_length_xor_packet_deframer_unit.sv =====
// Channel | Direction | Handshake                    | Payload
// cfg     | in        | cfg_valid_i / cfg_ready_o    | cfg_data_i (sync byte)
// in      | in        | in_valid_i / in_stall_o      | rx_byte_i
// out     | out       | out_valid_o / out_stall_i    | status_o, data_byte_o, is_command_o,
//         |           |                              | last_o
//
// Every received byte is taken while the input does not stall, the sync, length and body bytes as
// well as a byte that closes a frame with a status request.
// A checksum byte that passes starts a burst: each body byte passes through PH_READ
// and PH_LOAD on the single read port of the body buffer (address, then registered
// data), and the input stays stalled until the last body byte is loaded.
// Reset (rst_ni low, asynchronous) returns to idle with sync byte 0x13 and the
// output empty; the body buffer is not cleared, as only bytes of the current
// frame are ever read back.
// The input stalls during a burst and while a result waits on a stalled output.
module sync_length_xor_packet_deframer_unit
  import sxd_pkg::*;
#(
  parameter int unsigned MAX_BODY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  // received bytes
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  // results
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [7:0] data_byte_o,
  output logic       is_command_o,
  output logic       last_o
);

  localparam int unsigned AddrW = $clog2(MAX_BODY);
  localparam int unsigned CntW  = $clog2(MAX_BODY + 1);
  localparam logic [15:0] LenMax = 16'(MAX_BODY);

  phase_e            phase_q, phase_d;
  logic [7:0]        sync_q;
  logic [7:0]        run_xor_q, run_xor_d;
  logic [7:0]        len_hi_q, len_hi_d;
  logic [CntW-1:0]   frame_len_q, frame_len_d;
  logic [CntW-1:0]   body_cnt_q, body_cnt_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        status_q, status_d;
  logic [7:0]        data_byte_q, data_byte_d;
  logic              is_command_q, is_command_d;
  logic              last_q, last_d;

  logic              in_acc;
  logic              out_free;
  logic              ptr_last;
  logic [15:0]       full_len;
  logic              mem_we, mem_re;
  logic [7:0]        mem_rdata;

  // The sync register takes a write in any cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SYNC_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sync_q <= cfg_data_i;
    end
  end

  // Stall while the buffer is read back, and while a result waits on a stalled
  // output, so a status request always finds room in the output register.
  assign in_stall_o = (phase_q == PH_READ) || (phase_q == PH_LOAD) ||
                      (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full_len   = {len_hi_q, rx_byte_i};
  assign ptr_last   = (CntW'(rd_ptr_q) + CntW'(1)) == frame_len_q;

  sxd_buf #(
    .Depth(MAX_BODY)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(body_cnt_q[AddrW-1:0]),
    .wdata_i(rx_byte_i),
    .re_i   (mem_re),
    .raddr_i(rd_ptr_q),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    phase_d      = phase_q;
    run_xor_d    = run_xor_q;
    len_hi_d     = len_hi_q;
    frame_len_d  = frame_len_q;
    body_cnt_d   = body_cnt_q;
    rd_ptr_d     = rd_ptr_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    // drop the held result once it is taken
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    data_byte_d  = data_byte_q;
    is_command_d = is_command_q;
    last_d       = last_q;

    case (phase_q)
      PH_IDLE: begin
        // drop noise until the sync byte turns up
        if (in_acc && (rx_byte_i == sync_q)) begin
          run_xor_d  = rx_byte_i;
          body_cnt_d = '0;
          phase_d    = PH_LEN_HIGH;
        end
      end
      PH_LEN_HIGH: begin
        if (in_acc) begin
          len_hi_d  = rx_byte_i;
          run_xor_d = run_xor_q ^ rx_byte_i;
          phase_d   = PH_LEN_LOW;
        end
      end
      PH_LEN_LOW: begin
        if (in_acc) begin
          run_xor_d  = run_xor_q ^ rx_byte_i;
          body_cnt_d = '0;
          if (full_len == 16'd0) begin
            out_valid_d  = 1'b1;
            status_d     = ST_EMPTY;
            data_byte_d  = 8'd0;
            is_command_d = 1'b0;
            last_d       = 1'b1;
            frame_len_d  = '0;
            phase_d      = PH_IDLE;
          end else if (full_len > LenMax) begin
            out_valid_d  = 1'b1;
            status_d     = ST_TOO_LONG;
            data_byte_d  = 8'd0;
            is_command_d = 1'b0;
            last_d       = 1'b1;
            frame_len_d  = '0;
            phase_d      = PH_IDLE;
          end else begin
            frame_len_d = full_len[CntW-1:0];
            phase_d     = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (in_acc) begin
          if (body_cnt_q != frame_len_q) begin
            // store the body byte and fold it into the checksum
            mem_we     = 1'b1;
            run_xor_d  = run_xor_q ^ rx_byte_i;
            body_cnt_d = body_cnt_q + CntW'(1);
          end else if (rx_byte_i != run_xor_q) begin
            out_valid_d  = 1'b1;
            status_d     = ST_BAD_SUM;
            data_byte_d  = 8'd0;
            is_command_d = 1'b0;
            last_d       = 1'b1;
            frame_len_d  = '0;
            body_cnt_d   = '0;
            phase_d      = PH_IDLE;
          end else begin
            rd_ptr_d = '0;
            phase_d  = PH_READ;
          end
        end
      end
      PH_READ: begin
        mem_re  = 1'b1;
        phase_d = PH_LOAD;
      end
      PH_LOAD: begin
        // hold the read data until the output register has room
        if (out_free) begin
          out_valid_d  = 1'b1;
          status_d     = ST_BODY;
          data_byte_d  = mem_rdata;
          is_command_d = (rd_ptr_q == '0);
          last_d       = ptr_last;
          if (ptr_last) begin
            frame_len_d = '0;
            body_cnt_d  = '0;
            phase_d     = PH_IDLE;
          end else begin
            rd_ptr_d = rd_ptr_q + AddrW'(1);
            phase_d  = PH_READ;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      run_xor_q   <= '0;
      len_hi_q    <= '0;
      frame_len_q <= '0;
      body_cnt_q  <= '0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      run_xor_q   <= run_xor_d;
      len_hi_q    <= len_hi_d;
      frame_len_q <= frame_len_d;
      body_cnt_q  <= body_cnt_d;
      rd_ptr_q    <= rd_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    data_byte_q  <= data_byte_d;
    is_command_q <= is_command_d;
    last_q       <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign data_byte_o  = data_byte_q;
  assign is_command_o = is_command_q;
  assign last_o       = last_q;

  // The body count never runs past the announced length
  a_body_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (body_cnt_q <= frame_len_q))
    else $error("body count beyond frame length");

  // A frame in body or burst has a length the buffer can hold
  a_len_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY || phase_q == PH_READ || phase_q == PH_LOAD) |->
    (frame_len_q != '0 && CntW'(frame_len_q) <= CntW'(MAX_BODY)))
    else $error("frame length out of range");

  // Read data is only used the cycle after a read was issued or while held
  a_load_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LOAD) |-> ($past(phase_q) == PH_READ || $past(phase_q) == PH_LOAD))
    else $error("buffer data used without a read");

  // A status result is always a lone, final, empty result
  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_BODY) |->
    (last_o && !is_command_o && data_byte_o == 8'd0))
    else $error("malformed status result");

  // A checksum byte that matched starts a burst from the first body byte
  a_burst_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY && in_acc && body_cnt_q == frame_len_q &&
     rx_byte_i == run_xor_q) |=> (phase_q == PH_READ && rd_ptr_q == '0))
    else $error("burst not started after good checksum");

endmodule

// ===== test/sxd_frame_checker.sv =====
module sxd_frame_checker
  import sxd_pkg::*;
#(
  parameter int unsigned MAX_BODY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] rx_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [1:0] status_i,
  input  logic [7:0] data_byte_i,
  input  logic       is_command_i,
  input  logic       last_i,
  output int         mismatch_count_o,
  output int         awaited_o,
  output logic       frame_open_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AddrW = $clog2(MAX_BODY);

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data_byte;
    logic       is_command;
    logic       last;
  } deframed_t;

  deframed_t   deframed_q[$];
  logic [7:0]  sync_byte    = SYNC_RESET;
  phase_e      phase        = PH_IDLE;
  logic [7:0]  running_xor  = '0;
  logic [7:0]  length_high  = '0;
  logic [15:0] frame_length = '0;
  logic [15:0] body_count   = '0;
  logic [7:0]  body_mem [MAX_BODY];

  initial begin
    mismatch_count_o = 0;
    awaited_o        = 0;
    frame_open_o     = 1'b0;
  end

  // End the frame with a single status result
  task automatic close_frame(input logic [1:0] status);
    deframed_q.push_back('{status, 8'h00, 1'b0, 1'b1});
    phase        = PH_IDLE;
    frame_length = '0;
    body_count   = '0;
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    int k;
    case (phase)
      PH_IDLE: begin
        if (b == sync_byte) begin
          running_xor  = b;
          frame_length = '0;
          body_count   = '0;
          phase        = PH_LEN_HIGH;
        end
      end
      PH_LEN_HIGH: begin
        length_high = b;
        running_xor = running_xor ^ b;
        phase       = PH_LEN_LOW;
      end
      PH_LEN_LOW: begin
        frame_length = {length_high, b};
        running_xor  = running_xor ^ b;
        body_count   = '0;
        if (frame_length == 0) begin
          close_frame(ST_EMPTY);
        end else if (frame_length > MAX_BODY) begin
          close_frame(ST_TOO_LONG);
        end else begin
          phase = PH_BODY;
        end
      end
      default: begin
        if (body_count < frame_length) begin
          body_mem[body_count[AddrW-1:0]] = b;
          running_xor = running_xor ^ b;
          body_count  = body_count + 1'b1;
        end else if (b != running_xor) begin
          close_frame(ST_BAD_SUM);
        end else begin
          for (k = 0; k < body_count; k++) begin
            deframed_q.push_back('{ST_BODY, body_mem[AddrW'(k)], (k == 0),
                                   (k == body_count - 1)});
          end
          phase        = PH_IDLE;
          frame_length = '0;
          body_count   = '0;
        end
      end
    endcase
  endtask

  function automatic bit field_ok(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic check_result();
    deframed_t want;
    bit        ok;
    if (deframed_q.size() == 0) begin
      $display({"%0t ns: result with none awaited: expected nothing, ",
                "got status %0d data %0h cmd %0b last %0b"},
               $time, status_i, data_byte_i, is_command_i, last_i);
      mismatch_count_o++;
    end else begin
      want = deframed_q.pop_front();
      ok = field_ok("status", 8'(want.status), 8'(status_i))
         & field_ok("data_byte", want.data_byte, data_byte_i)
         & field_ok("is_command", 8'(want.is_command), 8'(is_command_i))
         & field_ok("last", 8'(want.last), 8'(last_i));
      if (!ok) mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deframed_q.delete();
      sync_byte    = SYNC_RESET;
      phase        = PH_IDLE;
      running_xor  = '0;
      length_high  = '0;
      frame_length = '0;
      body_count   = '0;
    end else begin
      // A byte taken at the same edge as a sync write still sees the old sync
      if (in_valid_i && !in_stall_i) deframe_byte(rx_byte_i);
      if (cfg_valid_i && cfg_ready_i) sync_byte = cfg_data_i;
      if (out_valid_i && !out_stall_i) check_result();
    end
    awaited_o    = deframed_q.size();
    frame_open_o = (phase != PH_IDLE);
  end

endmodule

// ===== test/sync_length_xor_packet_deframer_unit_test.sv =====
module sync_length_xor_packet_deframer_unit_test;
  import sxd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_BODY = 64;

  logic       clk_i;
  logic       rst_ni       = 1'b0;
  logic       cfg_valid_i  = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i   = '0;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i    = '0;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic [1:0] status_o;
  logic [7:0] data_byte_o;
  logic       is_command_o;
  logic       last_o;

  int         mismatch_count;
  int         awaited;
  logic       frame_open;

  // Sync byte the block currently holds, for building frames
  logic [7:0] sync_now  = SYNC_RESET;
  int         bytes_sent = 0;
  // Calm spells: while set, that side runs with no idle cycles
  bit         calm_in   = 1'b0;
  bit         calm_out  = 1'b0;

  sync_length_xor_packet_deframer_unit #(
    .MAX_BODY(MAX_BODY)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_byte_o (data_byte_o),
    .is_command_o(is_command_o),
    .last_o      (last_o)
  );

  sxd_frame_checker #(
    .MAX_BODY(MAX_BODY)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_i        (status_o),
    .data_byte_i     (data_byte_o),
    .is_command_i    (is_command_o),
    .last_i          (last_o),
    .mismatch_count_o(mismatch_count),
    .awaited_o       (awaited),
    .frame_open_o    (frame_open)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Toggle the calm spells on the falling edge, away from any sampling
  initial begin
    forever begin
      repeat ($urandom_range(20, 300)) @(negedge clk_i);
      calm_in  = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
    end
  end

  function automatic int in_gap();
    return calm_in ? 0 : $urandom_range(0, 16);
  endfunction

  // Offer one byte request. Enter and leave on a rising edge; valid stays
  // high on return, so the caller either offers the next byte at once or
  // drops valid itself.
  task automatic put_byte(input logic [7:0] b, input int gap);
    bit taken;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    // Decide on the falling edge, when stall has settled; the next rising
    // edge is then the acceptance
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    bytes_sent++;
  endtask

  // Send a frame: sync, length, then body_sent body bytes. A complete body
  // is closed with a checksum, corrupted unless good_sum is set. Zero and
  // oversize lengths stop after the length bytes, as the block closes them.
  task automatic send_frame(input logic [15:0] len, input int body_sent,
                            input bit good_sum);
    logic [7:0] sum;
    logic [7:0] b;
    int         k;
    sum = sync_now ^ len[15:8] ^ len[7:0];
    put_byte(sync_now, in_gap());
    put_byte(len[15:8], in_gap());
    put_byte(len[7:0], in_gap());
    if (len == 0 || len > MAX_BODY) return;
    for (k = 0; k < body_sent; k++) begin
      b   = 8'($urandom_range(0, 255));
      sum = sum ^ b;
      put_byte(b, in_gap());
    end
    if (body_sent < len) return;
    if (!good_sum) sum = sum ^ 8'($urandom_range(1, 255));
    put_byte(sum, in_gap());
  endtask

  // Hold the sender off until every awaited result has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (awaited != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Bring the block back to idle: pad any open frame with zero bytes until
  // it closes, drain the results and let the pipeline empty
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (frame_open) begin
      @(posedge clk_i);
      put_byte(8'h00, 0);
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    while (awaited != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_sync(input logic [7:0] value);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    sync_now = value;
    repeat (2) @(posedge clk_i);
  endtask

  // Mostly well-formed frames with random content; the rest is noise,
  // truncated frames, empty and oversize lengths, and full drains
  task automatic random_traffic(input int budget);
    int          stop_at;
    int          pick;
    logic [15:0] len;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        put_byte(8'($urandom_range(0, 255)), in_gap());
      end else if (pick < 11) begin
        send_frame(16'h0000, 0, 1'b1);
      end else if (pick < 14) begin
        send_frame(16'($urandom_range(MAX_BODY + 1, 16'hFFFF)), 0, 1'b1);
      end else if (pick < 18) begin
        len = 16'($urandom_range(1, 8));
        send_frame(len, $urandom_range(0, len - 1), 1'b1);
      end else if (pick < 22) begin
        drain_results();
      end else if (pick < 88) begin
        // Small frames: full body, checksum mostly good
        len = 16'($urandom_range(1, 8));
        send_frame(len, len, ($urandom_range(0, 5) != 0));
      end else begin
        len = ($urandom_range(0, 3) == 0) ? 16'(MAX_BODY)
                                          : 16'($urandom_range(9, MAX_BODY));
        send_frame(len, len, ($urandom_range(0, 5) != 0));
      end
    end
  endtask

  // Directed corner frames first, then random traffic under each sync byte
  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Noise at both extremes while idle; neither equals the reset sync byte
    put_byte(8'h00, in_gap());
    put_byte(8'hFF, in_gap());
    // Empty frame closes on the second length byte
    send_frame(16'h0000, 0, 1'b1);
    // Oversize lengths: all ones, one past the buffer, high byte alone
    send_frame(16'hFFFF, 0, 1'b1);
    send_frame(16'(MAX_BODY + 1), 0, 1'b1);
    send_frame(16'h0100, 0, 1'b1);
    // Shortest good frame, then a bad checksum
    send_frame(16'd1, 1, 1'b1);
    send_frame(16'd2, 2, 1'b0);
    settle_idle();

    random_traffic(25);
    // A full-size body once at least
    send_frame(16'(MAX_BODY), MAX_BODY, 1'b1);
    drain_results();

    settle_idle();
    write_sync(8'h00);
    random_traffic(25);

    settle_idle();
    write_sync(8'hFF);
    random_traffic(25);

    settle_idle();
    write_sync(8'($urandom_range(0, 255)));
    random_traffic(25);

    // Drop valid, wait for the last results, then allow a full burst more
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (awaited != 0) @(negedge clk_i);
    repeat (2 * MAX_BODY + 16) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("sync_length_xor_packet_deframer_unit: match");
    end else begin
      $display("sync_length_xor_packet_deframer_unit: mismatch");
    end
    $finish;
  end

  // Receiver: stall for a random spell before each result request
  initial begin : receiver
    int hold;
    bit taken;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      hold = calm_out ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do begin
        @(negedge clk_i);
        taken = out_valid_o;
        @(posedge clk_i);
      end while (!taken);
    end
  end

  // Timeout: far beyond the slowest correct run
  initial begin : watchdog
    #(2_000_000);
    $display("sync_length_xor_packet_deframer_unit: mismatch");
    $finish;
  end

endmodule
